// File: rtl/core/hrpd_pkg.sv
// Shared types, constants and the elaboration-time ratio table builder for the HSI-to-RGB duty block.
package hrpd_pkg;

  // field widths
  localparam int unsigned ADC_W      = 13;
  localparam int unsigned SAT_W      = 9;
  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned DUTY_W     = 16;
  localparam int unsigned RATIO_W    = 19;
  localparam int unsigned COMP_W     = 17;
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  // Q1.8 unity and register reset values
  localparam int unsigned UNITY          = 256;
  localparam int unsigned SAT_RESET      = 256;
  localparam int unsigned INTEN_RESET    = 128;
  localparam int unsigned PERIOD_RESET   = 8000;

  // angle constants in Q28
  localparam logic [63:0] ONE_Q28      = 64'd268435456;
  localparam logic [63:0] PI_Q28       = 64'd843314857;
  localparam logic [63:0] PI_THIRD_Q28 = PI_Q28 / 3;

  // register indexes
  typedef enum logic [1:0] {
    CFG_SATURATION = 2'd0,
    CFG_INTENSITY  = 2'd1,
    CFG_PWM_PERIOD = 2'd2
  } cfg_idx_e;

  // 120-degree sector, named after the component that leads it
  typedef enum logic [1:0] {
    SECTOR_RED   = 2'd0,
    SECTOR_GREEN = 2'd1,
    SECTOR_BLUE  = 2'd2
  } sector_e;

  typedef struct packed {
    logic [SAT_W-1:0]    saturation;
    logic [SAT_W-1:0]    intensity;
    logic [PERIOD_W-1:0] pwm_period;
  } cfg_t;

  typedef struct packed {
    logic    valid;
    sector_e sector;
  } hue_t;

  // Restoring division, evaluated only while building constants.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Cosine by a thirteen-term Taylor series, Q28 in and out.
  function automatic logic signed [63:0] cos_q28(input logic signed [63:0] x);
    logic [63:0]        ax;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    ax   = x[63] ? $unsigned(-x) : $unsigned(x);
    x2   = (ax * ax) >> 28;
    term = ONE_Q28;
    sum  = $signed(ONE_Q28);
    term = ((term * x2) >> 28) / 64'd2;   sum = sum - $signed(term);
    term = ((term * x2) >> 28) / 64'd12;  sum = sum + $signed(term);
    term = ((term * x2) >> 28) / 64'd30;  sum = sum - $signed(term);
    term = ((term * x2) >> 28) / 64'd56;  sum = sum + $signed(term);
    term = ((term * x2) >> 28) / 64'd90;  sum = sum - $signed(term);
    term = ((term * x2) >> 28) / 64'd132; sum = sum + $signed(term);
    term = ((term * x2) >> 28) / 64'd182; sum = sum - $signed(term);
    term = ((term * x2) >> 28) / 64'd240; sum = sum + $signed(term);
    term = ((term * x2) >> 28) / 64'd306; sum = sum - $signed(term);
    term = ((term * x2) >> 28) / 64'd380; sum = sum + $signed(term);
    term = ((term * x2) >> 28) / 64'd462; sum = sum - $signed(term);
    term = ((term * x2) >> 28) / 64'd552; sum = sum + $signed(term);
    return sum;
  endfunction

  // One entry of cos(a)/cos(60deg - a) in signed Q16, rounded to nearest.
  function automatic logic signed [RATIO_W-1:0] ratio_entry(input int unsigned idx,
                                                            input int unsigned entries);
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic signed [63:0] num;
    logic signed [63:0] den;
    logic signed [63:0] res;
    logic [63:0]        mag;
    logic [63:0]        q;
    a   = $signed(udiv64(64'(idx) * 64'd2 * PI_Q28, 64'(entries) * 64'd3));
    b   = $signed(PI_THIRD_Q28) - a;
    num = cos_q28(a);
    den = cos_q28(b);
    if (den <= 64'sd0) begin
      den = 64'sd1;
    end
    mag = num[63] ? $unsigned(-num) : $unsigned(num);
    q   = udiv64((mag << 16) + ($unsigned(den) >> 1), $unsigned(den));
    res = num[63] ? -$signed(q) : $signed(q);
    return res[RATIO_W-1:0];
  endfunction

endpackage

// File: rtl/core/hsi_to_rgb_pwm_duty.sv
// Top level of the HSI-to-RGB PWM duty converter.
// A result strobes on done_o once its start transfer has passed the hue pipeline, ROM read and component pipeline.
// Throughput: one transfer per cycle; busy stays low and the ratio ROM is read once per item.
// Reset (rst_ni, asynchronous, active low) clears all valid bits and loads
// saturation 256, intensity 128 and period 8000. The receiver cannot stall.
module hsi_to_rgb_pwm_duty #(
  parameter int unsigned RATIO_TABLE_ENTRIES = 256,
  parameter int unsigned HUE_FRACTION_BITS   = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [hrpd_pkg::ADC_W-1:0]       adc_mv_i,
  output logic                             done_o,
  output logic [hrpd_pkg::DUTY_W-1:0]      red_duty_o,
  output logic [hrpd_pkg::DUTY_W-1:0]      green_duty_o,
  output logic [hrpd_pkg::DUTY_W-1:0]      blue_duty_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [hrpd_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [hrpd_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [hrpd_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import hrpd_pkg::*;

  localparam int unsigned IW = $clog2(RATIO_TABLE_ENTRIES);

  cfg_t                      cfg;
  hue_t                      hue;
  logic [IW-1:0]             idx;
  logic signed [RATIO_W-1:0] ratio;

  // every cycle takes a new transfer
  assign busy = 1'b0;

  hrpd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  hrpd_hue #(
    .RATIO_TABLE_ENTRIES (RATIO_TABLE_ENTRIES),
    .HUE_FRACTION_BITS   (HUE_FRACTION_BITS)
  ) u_hue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (start & ~busy),
    .adc_mv_i (adc_mv_i),
    .hue_o    (hue),
    .idx_o    (idx)
  );

  hrpd_rom #(
    .RATIO_TABLE_ENTRIES (RATIO_TABLE_ENTRIES)
  ) u_rom (
    .clk_i   (clk_i),
    .idx_i   (idx),
    .ratio_o (ratio)
  );

  hrpd_comp u_comp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .hue_i        (hue),
    .ratio_i      (ratio),
    .cfg_i        (cfg),
    .done_o       (done_o),
    .red_duty_o   (red_duty_o),
    .green_duty_o (green_duty_o),
    .blue_duty_o  (blue_duty_o)
  );

endmodule

// File: rtl/core/hrpd_cfg.sv
// APB-style register file holding saturation, intensity and PWM period.
module hrpd_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [hrpd_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [hrpd_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [hrpd_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready,
  output hrpd_pkg::cfg_t                   cfg_o
);
  import hrpd_pkg::*;

  cfg_t     cfg_q, cfg_d;
  cfg_idx_e reg_idx;
  logic     wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = cfg_idx_e'(paddr[3:2]);

  // decode a write transfer
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        CFG_SATURATION: cfg_d.saturation = pwdata[SAT_W-1:0];
        CFG_INTENSITY:  cfg_d.intensity  = pwdata[SAT_W-1:0];
        CFG_PWM_PERIOD: cfg_d.pwm_period = pwdata[PERIOD_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  // hold the registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.saturation <= SAT_W'(SAT_RESET);
      cfg_q.intensity  <= SAT_W'(INTEN_RESET);
      cfg_q.pwm_period <= PERIOD_W'(PERIOD_RESET);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read back
  always_comb begin
    unique case (reg_idx)
      CFG_SATURATION: prdata = CFG_DATA_W'(cfg_q.saturation);
      CFG_INTENSITY:  prdata = CFG_DATA_W'(cfg_q.intensity);
      CFG_PWM_PERIOD: prdata = CFG_DATA_W'(cfg_q.pwm_period);
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/hrpd_hue.sv
// Hue pipeline: millivolts to hue, wrap, sector split and ratio table index.
module hrpd_hue #(
  parameter int unsigned RATIO_TABLE_ENTRIES = 256,
  parameter int unsigned HUE_FRACTION_BITS   = 4
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  input  logic [hrpd_pkg::ADC_W-1:0]             adc_mv_i,
  output hrpd_pkg::hue_t                         hue_o,
  output logic [$clog2(RATIO_TABLE_ENTRIES)-1:0] idx_o
);
  import hrpd_pkg::*;

  // mv * 9 fits ADC_W + 4 bits, then the hue fraction is shifted in
  localparam int unsigned XW         = ADC_W + 4 + HUE_FRACTION_BITS;
  localparam int unsigned D125_SHIFT = XW;
  localparam int unsigned D125_MUL   = (1 << D125_SHIFT) / 125;
  localparam int unsigned MW         = XW - 6;
  localparam int unsigned PW         = XW + MW;
  localparam int unsigned QW         = XW - 6;
  localparam int unsigned HUE_FULL   = 360 << HUE_FRACTION_BITS;
  localparam int unsigned HUE_SECTOR = 120 << HUE_FRACTION_BITS;
  localparam int unsigned HW         = $clog2(HUE_FULL);
  localparam int unsigned OW         = $clog2(HUE_SECTOR);
  localparam int unsigned IW         = $clog2(RATIO_TABLE_ENTRIES);
  localparam int unsigned TW         = $clog2(HUE_SECTOR * RATIO_TABLE_ENTRIES);
  localparam int unsigned DSEC_MUL   = (1 << TW) / HUE_SECTOR;
  localparam int unsigned IDX_MUL    = RATIO_TABLE_ENTRIES * DSEC_MUL;
  localparam int unsigned CW         = $clog2(IDX_MUL + 1);
  localparam int unsigned P2W        = OW + CW;

  // stage 1: scaled reading and reciprocal product for the divide by 125
  logic          v1_q;
  logic [XW-1:0] x1_q, x1_d;
  logic [PW-1:0] p1_q, p1_d;
  // stage 2: quotient estimate and remainder
  logic          v2_q;
  logic [QW-1:0] q2_q, q2_d;
  logic [7:0]    r2_q, r2_d;
  // stage 3: wrapped hue
  logic          v3_q;
  logic [HW-1:0] hue3_q, hue3_d;
  logic [QW-1:0] hue_raw;
  // stage 4: sector and offset
  hue_t          h4_q, h4_d;
  logic [OW-1:0] off4_q, off4_d;
  // stage 5: index product and scaled offset
  hue_t          h5_q;
  logic [P2W-1:0] p5_q, p5_d;
  logic [TW-1:0] t5_q, t5_d;
  // stage 6: corrected index
  hue_t          h6_q;
  logic [IW-1:0] idx6_q, idx6_d;
  logic [IW-1:0] i_est;
  logic [TW-1:0] i_rem;

  // scale the reading and multiply by the reciprocal of 125
  always_comb begin
    x1_d = ((XW'(adc_mv_i) << 3) + XW'(adc_mv_i)) << HUE_FRACTION_BITS;
    p1_d = PW'(x1_d) * PW'(MW'(D125_MUL));
  end

  // take the estimate and its remainder
  always_comb begin
    logic [XW-1:0] rem_full;
    q2_d     = p1_q[PW-1:D125_SHIFT];
    rem_full = x1_q - XW'(q2_d) * XW'(125);
    r2_d     = rem_full[7:0];
  end

  // correct the quotient and wrap past 360 degrees
  always_comb begin
    hue_raw = q2_q + QW'(r2_q >= 8'd125);
    if (hue_raw >= QW'(HUE_FULL)) begin
      hue_raw = hue_raw - QW'(HUE_FULL);
    end
    hue3_d = hue_raw[HW-1:0];
  end

  // split into sector and offset
  always_comb begin
    logic [HW-1:0] off_full;
    h4_d.valid = v3_q;
    if (hue3_q < HW'(HUE_SECTOR)) begin
      h4_d.sector = SECTOR_RED;
      off_full    = hue3_q;
    end else if (hue3_q < HW'(2 * HUE_SECTOR)) begin
      h4_d.sector = SECTOR_GREEN;
      off_full    = hue3_q - HW'(HUE_SECTOR);
    end else begin
      h4_d.sector = SECTOR_BLUE;
      off_full    = hue3_q - HW'(2 * HUE_SECTOR);
    end
    off4_d = off_full[OW-1:0];
  end

  // scale the offset to table entries with a reciprocal of the sector width
  always_comb begin
    p5_d = P2W'(off4_q) * P2W'(IDX_MUL);
    t5_d = TW'(off4_q) * TW'(RATIO_TABLE_ENTRIES);
  end

  // correct the index estimate by one step
  always_comb begin
    i_est  = p5_q[TW +: IW];
    i_rem  = t5_q - TW'(i_est) * TW'(HUE_SECTOR);
    idx6_d = i_est + IW'(i_rem >= TW'(HUE_SECTOR));
  end

  // advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      h4_q <= '0;
      h5_q <= '0;
      h6_q <= '0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      h4_q <= h4_d;
      h5_q <= h4_q;
      h6_q <= h5_q;
    end
  end

  // advance the payload
  always_ff @(posedge clk_i) begin
    x1_q   <= x1_d;
    p1_q   <= p1_d;
    q2_q   <= q2_d;
    r2_q   <= r2_d;
    hue3_q <= hue3_d;
    off4_q <= off4_d;
    p5_q   <= p5_d;
    t5_q   <= t5_d;
    idx6_q <= idx6_d;
  end

  assign hue_o = h6_q;
  assign idx_o = idx6_q;

endmodule

// File: rtl/core/hrpd_rom.sv
// Constant cosine-ratio ROM with a registered read port.
module hrpd_rom #(
  parameter int unsigned RATIO_TABLE_ENTRIES = 256
) (
  input  logic                                   clk_i,
  input  logic [$clog2(RATIO_TABLE_ENTRIES)-1:0] idx_i,
  output logic signed [hrpd_pkg::RATIO_W-1:0]    ratio_o
);
  import hrpd_pkg::*;

  logic signed [RATIO_W-1:0] rom_w [RATIO_TABLE_ENTRIES];
  logic signed [RATIO_W-1:0] ratio_q;

  // fill the table at elaboration
  for (genvar g = 0; g < RATIO_TABLE_ENTRIES; g++) begin : g_entry
    localparam logic signed [RATIO_W-1:0] RATIO_VAL = ratio_entry(g, RATIO_TABLE_ENTRIES);
    assign rom_w[g] = RATIO_VAL;
  end

  // register the read
  always_ff @(posedge clk_i) begin
    ratio_q <= rom_w[idx_i];
  end

  assign ratio_o = ratio_q;

endmodule

// File: rtl/core/hrpd_comp.sv
// Component pipeline: HSI mixing, clamping and PWM duty scaling.
module hrpd_comp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  hrpd_pkg::hue_t                    hue_i,
  input  logic signed [hrpd_pkg::RATIO_W-1:0] ratio_i,
  input  hrpd_pkg::cfg_t                    cfg_i,
  output logic                              done_o,
  output logic [hrpd_pkg::DUTY_W-1:0]       red_duty_o,
  output logic [hrpd_pkg::DUTY_W-1:0]       green_duty_o,
  output logic [hrpd_pkg::DUTY_W-1:0]       blue_duty_o
);
  import hrpd_pkg::*;

  // divide by 3 through a rounded-up reciprocal; exact over the ranges used
  localparam int unsigned DIV3_SHIFT    = 20;
  localparam int unsigned DIV3_MUL      = ((1 << DIV3_SHIFT) + 2) / 3;
  localparam int unsigned DIV3_SM_SHIFT = 9;
  localparam int unsigned DIV3_SM_MUL   = ((1 << DIV3_SM_SHIFT) + 2) / 3;
  localparam int unsigned DIV3_BULK     = UNITY / 3;
  localparam int unsigned NW            = 26;
  localparam int unsigned MIN_W         = 15;
  localparam int unsigned PR_W          = COMP_W + PERIOD_W;
  localparam int unsigned FULL_W        = PR_W + SAT_W;

  logic [SAT_W-1:0] sat_eff, iv_eff;

  hue_t a_q, b_q, c_q, d_q;
  logic ve_q, vf_q;

  logic signed [RATIO_W-1:0] ratio_a;
  logic signed [28:0]  mix_prod, mix_sum;
  logic [NW-1:0]       num_b_q, num_b_d;
  logic [36:0]         main_prod;
  logic [COMP_W-1:0]   main_c_q, main_c_d;
  logic [MIN_W-1:0]    minor_c_q, minor_c_d;
  logic [SAT_W-1:0]    minor_v;
  logic [15:0]         minor_lo;
  logic [COMP_W-1:0]   comp_d_q [3];
  logic [COMP_W-1:0]   comp_d_d [3];
  logic [PR_W-1:0]     pr_e_q [3];
  logic [PR_W-1:0]     pr_e_d [3];
  logic [DUTY_W-1:0]   duty_q [3];
  logic [DUTY_W-1:0]   duty_d [3];

  // clamp the Q1.8 registers at unity
  assign sat_eff = (cfg_i.saturation > SAT_W'(UNITY)) ? SAT_W'(UNITY) : cfg_i.saturation;
  assign iv_eff  = (cfg_i.intensity > SAT_W'(UNITY)) ? SAT_W'(UNITY) : cfg_i.intensity;
  assign ratio_a = ratio_i;

  // main numerator: one plus saturation times ratio, dropped at zero
  always_comb begin
    mix_prod = $signed({1'b0, sat_eff}) * ratio_a;
    mix_sum  = 29'sd16777216 + mix_prod;
    num_b_d  = mix_sum[28] ? '0 : mix_sum[NW-1:0];
  end

  // main over 768 and the minor component
  always_comb begin
    main_prod = 37'(num_b_q[NW-1:8]) * 37'(DIV3_MUL);
    main_c_d  = main_prod[DIV3_SHIFT +: COMP_W];
    minor_v   = SAT_W'(UNITY) - sat_eff;
    minor_lo  = 16'(minor_v) * 16'(DIV3_SM_MUL);
    minor_c_d = MIN_W'(17'(minor_v) * 17'(DIV3_BULK) + 17'(minor_lo[15:DIV3_SM_SHIFT]));
  end

  // place main, minor and rest by sector, or grey on all three when saturation is zero
  always_comb begin
    logic signed [18:0] rest_s;
    logic [COMP_W-1:0]  rest;
    logic [COMP_W-1:0]  minor;
    logic [COMP_W-1:0]  grey;
    rest_s = 19'sd65536 - $signed({2'b00, main_c_q}) - $signed({4'b0000, minor_c_q});
    rest   = rest_s[18] ? '0 : rest_s[COMP_W-1:0];
    minor  = COMP_W'(minor_c_q);
    grey   = {iv_eff, 8'h00};
    case (c_q.sector)
      SECTOR_RED: begin
        comp_d_d[0] = main_c_q;
        comp_d_d[1] = rest;
        comp_d_d[2] = minor;
      end
      SECTOR_GREEN: begin
        comp_d_d[0] = minor;
        comp_d_d[1] = main_c_q;
        comp_d_d[2] = rest;
      end
      default: begin
        comp_d_d[0] = rest;
        comp_d_d[1] = minor;
        comp_d_d[2] = main_c_q;
      end
    endcase
    if (sat_eff == '0) begin
      comp_d_d[0] = grey;
      comp_d_d[1] = grey;
      comp_d_d[2] = grey;
    end
  end

  // scale by period, then by intensity, and saturate
  always_comb begin
    logic [FULL_W-1:0] full;
    logic [FULL_W-25:0] shifted;
    for (int c = 0; c < 3; c++) begin
      pr_e_d[c] = PR_W'(comp_d_q[c]) * PR_W'(cfg_i.pwm_period);
      full      = FULL_W'(pr_e_q[c]) * FULL_W'(iv_eff);
      shifted   = full[FULL_W-1:24];
      duty_d[c] = (shifted > (FULL_W-24)'(16'hFFFF)) ? 16'hFFFF : shifted[DUTY_W-1:0];
    end
  end

  // advance the valid bits and sectors
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q  <= '0;
      b_q  <= '0;
      c_q  <= '0;
      d_q  <= '0;
      ve_q <= 1'b0;
      vf_q <= 1'b0;
    end else begin
      a_q  <= hue_i;
      b_q  <= a_q;
      c_q  <= b_q;
      d_q  <= c_q;
      ve_q <= d_q.valid;
      vf_q <= ve_q;
    end
  end

  // advance the payload
  always_ff @(posedge clk_i) begin
    num_b_q   <= num_b_d;
    main_c_q  <= main_c_d;
    minor_c_q <= minor_c_d;
    for (int c = 0; c < 3; c++) begin
      comp_d_q[c] <= comp_d_d[c];
      pr_e_q[c]   <= pr_e_d[c];
      duty_q[c]   <= duty_d[c];
    end
  end

  assign done_o       = vf_q;
  assign red_duty_o   = duty_q[0];
  assign green_duty_o = duty_q[1];
  assign blue_duty_o  = duty_q[2];

endmodule
